// ===== rtl/core/hesc_pkg.sv =====
// ----------------------------------------------------------------------------
// hesc_pkg
// Shared types, entity codes and entity text lookup for the html escape encoder.
// ----------------------------------------------------------------------------
package hesc_pkg;

    typedef logic [2:0] esc_code_t;
    typedef logic [2:0] esc_pos_t;

    localparam esc_code_t ESC_NONE = 3'd0;
    localparam esc_code_t ESC_QUOT = 3'd1;
    localparam esc_code_t ESC_AMP  = 3'd2;
    localparam esc_code_t ESC_APOS = 3'd3;
    localparam esc_code_t ESC_SLSH = 3'd4;
    localparam esc_code_t ESC_LT   = 3'd5;
    localparam esc_code_t ESC_GT   = 3'd6;

    localparam logic [7:0] HIGH_MASK = 8'h7F;

    // one output byte with its flags, moving from the hold stage to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } sym_t;

    function automatic esc_code_t classify(input logic [7:0] b);
        esc_code_t code;
        unique case (b)
            8'h22:   code = ESC_QUOT;
            8'h26:   code = ESC_AMP;
            8'h27:   code = ESC_APOS;
            8'h2F:   code = ESC_SLSH;
            8'h3C:   code = ESC_LT;
            8'h3E:   code = ESC_GT;
            default: code = ESC_NONE;
        endcase
        return code;
    endfunction

    function automatic esc_pos_t ent_len(input esc_code_t code);
        esc_pos_t len;
        unique case (code)
            ESC_QUOT: len = 3'd6;
            ESC_AMP:  len = 3'd5;
            ESC_APOS: len = 3'd5;
            ESC_SLSH: len = 3'd5;
            ESC_LT:   len = 3'd4;
            ESC_GT:   len = 3'd4;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] ent_char(input esc_code_t code, input esc_pos_t pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos == 3'd0)
        begin
            c = "&";
        end
        else
        begin
            unique case (code)
                ESC_QUOT:
                begin
                    unique case (pos)
                        3'd1:    c = "q";
                        3'd2:    c = "u";
                        3'd3:    c = "o";
                        3'd4:    c = "t";
                        3'd5:    c = ";";
                        default: c = 8'h00;
                    endcase
                end
                ESC_AMP:
                begin
                    unique case (pos)
                        3'd1:    c = "a";
                        3'd2:    c = "m";
                        3'd3:    c = "p";
                        3'd4:    c = ";";
                        default: c = 8'h00;
                    endcase
                end
                ESC_APOS:
                begin
                    unique case (pos)
                        3'd1:    c = "#";
                        3'd2:    c = "3";
                        3'd3:    c = "9";
                        3'd4:    c = ";";
                        default: c = 8'h00;
                    endcase
                end
                ESC_SLSH:
                begin
                    unique case (pos)
                        3'd1:    c = "#";
                        3'd2:    c = "4";
                        3'd3:    c = "7";
                        3'd4:    c = ";";
                        default: c = 8'h00;
                    endcase
                end
                ESC_LT:
                begin
                    unique case (pos)
                        3'd1:    c = "l";
                        3'd2:    c = "t";
                        3'd3:    c = ";";
                        default: c = 8'h00;
                    endcase
                end
                ESC_GT:
                begin
                    unique case (pos)
                        3'd1:    c = "g";
                        3'd2:    c = "t";
                        3'd3:    c = ";";
                        default: c = 8'h00;
                    endcase
                end
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/hesc_hold.sv =====
// ----------------------------------------------------------------------------
// hesc_hold
// Input register stage: holds one text byte and steps through its entity bytes.
// ----------------------------------------------------------------------------
module hesc_hold (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    input  logic          take,
    output hesc_pkg::sym_t sym
);
    import hesc_pkg::*;

    logic       valid_reg, valid_next;
    esc_code_t  code_reg, code_next;
    esc_pos_t   pos_reg, pos_next;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic       last;
    logic       accept;
    esc_code_t  in_code;

    // high bytes never escape
    assign in_code = ((in_byte & HIGH_MASK) == in_byte) ? classify(in_byte) : ESC_NONE;

    assign last     = (code_reg == ESC_NONE) || (pos_reg == ent_len(code_reg) - 3'd1);
    assign in_ready = !valid_reg || (take && last);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sym.valid    = valid_reg;
        sym.data     = (code_reg == ESC_NONE) ? byte_reg : ent_char(code_reg, pos_reg);
        sym.run_last = last;
        sym.text_end = last && end_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        pos_next   = pos_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
                pos_next   = 3'd0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        if (accept)
        begin
            valid_next = 1'b1;
            code_next  = in_code;
            pos_next   = 3'd0;
            byte_next  = in_byte;
            end_next   = in_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            code_reg  <= ESC_NONE;
            pos_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            code_reg  <= code_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (pos_reg < ent_len(code_reg)))
        else $error("entity position past entity length");

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> (pos_reg == 3'd0))
        else $error("position not cleared while empty");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (valid_reg && $stable(code_reg) && pos_reg == $past(pos_reg) + 3'd1))
        else $error("entity run broken before its last byte");

endmodule

// ===== rtl/core/hesc_out.sv =====
// ----------------------------------------------------------------------------
// hesc_out
// Output register: loads one escaped byte whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module hesc_out (
    input  logic           clk,
    input  logic           rst_n,
    input  hesc_pkg::sym_t sym,
    output logic           take,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           text_end
);
    import hesc_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       text_end_reg;

    assign take = sym.valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg     <= sym.data;
            run_last_reg <= sym.run_last;
            text_end_reg <= sym.text_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;

endmodule

// ===== rtl/core/html_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// html_escape_encoder
// Escapes html special characters in a byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready carry one text byte (in_byte) and the
// end-of-text mark (in_end) per transaction
// output channel: out_valid / out_ready carry one escaped byte (out_byte),
// run_last on the final byte produced by an input byte, and text_end on the
// final byte produced by the byte marked as end of text
// quote, ampersand, apostrophe, slash, less-than and greater-than expand to
// their entities; every other byte, high bytes included, passes unchanged
// throughput: one plain byte per cycle while the receiver does not stall; an
// escaped byte gives its entity length (4 to 6 bytes), stepped through by the single hold register
// reset: both stages empty, in_ready high, out_valid low
// receiver stall: the output register holds its byte; the hold stage keeps
// one byte, so one transaction is taken while a result waits, then in_ready
// drops until out_ready returns
// ----------------------------------------------------------------------------
module html_escape_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);
    import hesc_pkg::*;

    sym_t sym;
    logic take;

    hesc_hold u_hold (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_end   (in_end),
        .take     (take),
        .sym      (sym)
    );

    hesc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym       (sym),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the html escape encoder against a predictor of the entity expansion.
// A short table of directed bytes comes first: the byte extremes, every
// special character, and high bytes that alias a special character in their
// low seven bits. Random texts follow, mostly well formed with the end mark
// on their final byte, with some noise. Both channels idle at random, with
// stretches of no idling. Every output byte is compared with the oldest
// expected byte.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 128;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } esc_sym_t;

    typedef struct {
        logic [7:0] chr;
        logic       last_of_text;
        bit         typed;
        logic [7:0] typed_out;
    } text_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    esc_sym_t  escaped_q[$];
    text_row_t sent_rows[$];
    text_row_t dir_tab[$];
    text_row_t acc_row;
    esc_sym_t  exp_sym;
    bit        quiet;
    int        fail_count;
    int        idle_cycles;

    html_escape_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_end    (in_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void escape_byte(input logic [7:0] b, input logic e);
        string    ent;
        esc_sym_t s;
        case (b)
            8'h22:   ent = "&quot;";
            8'h26:   ent = "&amp;";
            8'h27:   ent = "&#39;";
            8'h2F:   ent = "&#47;";
            8'h3C:   ent = "&lt;";
            8'h3E:   ent = "&gt;";
            default: ent = "";
        endcase
        if (ent.len() == 0)
        begin
            s.data     = b;
            s.run_last = 1'b1;
            s.text_end = e;
            escaped_q.push_back(s);
        end
        else
        begin
            for (int i = 0; i < ent.len(); i++)
            begin
                s.data     = ent[i];
                s.run_last = (i == ent.len() - 1);
                s.text_end = s.run_last & e;
                escaped_q.push_back(s);
            end
        end
    endfunction

    function automatic text_row_t mk_row(input logic [7:0] b, input logic e,
                                         input bit typed, input logic [7:0] typed_out);
        text_row_t r;
        r.chr          = b;
        r.last_of_text = e;
        r.typed        = typed;
        r.typed_out    = typed_out;
        return r;
    endfunction

    function automatic logic [7:0] special_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = 8'h22;
            1:       c = 8'h26;
            2:       c = 8'h27;
            3:       c = 8'h2F;
            4:       c = 8'h3C;
            default: c = 8'h3E;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = special_char();
            4, 5, 6:    c = 8'($urandom_range(8'h20, 8'h7E));
            7:          c = special_char() | 8'h80;
            default:    c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic send_row(input text_row_t row);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sent_rows.push_back(row);
        in_valid <= 1'b1;
        in_byte  <= row.chr;
        in_end   <= row.last_of_text;
        do @(posedge clk); while (!in_ready);
    endtask

    // expected bytes for every accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            acc_row = sent_rows.pop_front();
            if (acc_row.typed)
            begin
                exp_sym.data     = acc_row.typed_out;
                exp_sym.run_last = 1'b1;
                exp_sym.text_end = acc_row.last_of_text;
                escaped_q.push_back(exp_sym);
            end
            else
            begin
                escape_byte(in_byte, in_end);
            end
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (escaped_q.size() == 0)
            begin
                if (fail_count < REPORT_MAX)
                begin
                    $display("unexpected output: byte %02h run_last %b text_end %b",
                             out_byte, run_last, text_end);
                end
                fail_count++;
            end
            else
            begin
                exp_sym = escaped_q.pop_front();
                if (out_byte !== exp_sym.data || run_last !== exp_sym.run_last ||
                    text_end !== exp_sym.text_end)
                begin
                    if (fail_count < REPORT_MAX)
                    begin
                        $display({"mismatch: expected byte %02h run_last %b text_end %b,",
                                  " got byte %02h run_last %b text_end %b"},
                                 exp_sym.data, exp_sym.run_last, exp_sym.text_end,
                                 out_byte, run_last, text_end);
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("** html_escape_encoder: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver side
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        text_row_t row;
        int        n;
        int        seg;
        int        len;
        bit        noisy;
        fail_count  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        in_end   <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        dir_tab.push_back(mk_row(8'h00, 1'b0, 1'b1, 8'h00));
        dir_tab.push_back(mk_row(8'hFF, 1'b1, 1'b1, 8'hFF));
        dir_tab.push_back(mk_row(8'h22, 1'b0, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h26, 1'b0, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h27, 1'b0, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h2F, 1'b0, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h3C, 1'b0, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h3E, 1'b1, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h22, 1'b1, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h3C, 1'b0, 1'b0, 8'h00));
        dir_tab.push_back(mk_row(8'h2F, 1'b1, 1'b0, 8'h00));
        // high bytes aliasing special characters pass through
        dir_tab.push_back(mk_row(8'hA2, 1'b0, 1'b1, 8'hA2));
        dir_tab.push_back(mk_row(8'hA6, 1'b0, 1'b1, 8'hA6));
        dir_tab.push_back(mk_row(8'hA7, 1'b0, 1'b1, 8'hA7));
        dir_tab.push_back(mk_row(8'hAF, 1'b0, 1'b1, 8'hAF));
        dir_tab.push_back(mk_row(8'hBC, 1'b0, 1'b1, 8'hBC));
        dir_tab.push_back(mk_row(8'hBE, 1'b1, 1'b1, 8'hBE));
        dir_tab.push_back(mk_row(8'h7F, 1'b0, 1'b1, 8'h7F));
        dir_tab.push_back(mk_row(8'h80, 1'b1, 1'b1, 8'h80));
        dir_tab.push_back(mk_row(8'h3D, 1'b0, 1'b1, 8'h3D));
        dir_tab.push_back(mk_row(8'h41, 1'b1, 1'b1, 8'h41));
        foreach (dir_tab[i])
        begin
            send_row(dir_tab[i]);
        end

        // random texts, in segments with or without idling
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 2) == 0);
            seg   = 0;
            while (seg < 20 && n < RANDOM_ITEMS)
            begin
                len   = $urandom_range(1, 12);
                noisy = ($urandom_range(0, 4) == 0);
                for (int k = 0; k < len; k++)
                begin
                    row.chr          = rand_char();
                    row.last_of_text = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
                    row.typed        = 1'b0;
                    row.typed_out    = 8'h00;
                    send_row(row);
                    n++;
                    seg++;
                end
            end
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (escaped_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && escaped_q.size() == 0)
        begin
            $display("** html_escape_encoder: PASSED **");
        end
        else
        begin
            $display("** html_escape_encoder: FAILED **");
        end
        $finish;
    end

endmodule
